### hw/rtl/lrs_pkg.sv
package lrs_pkg;

	// Fixed field widths of the words on the ports.
	localparam int LINE_W = 64;
	localparam int CPL_W = 7;
	localparam logic [CPL_W-1:0] CPL_RESET = 7'd64;

	// Output queue geometry.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_IDX_W = 2;
	localparam int OQ_CNT_W = 3;

	typedef struct packed {
		logic [LINE_W-1:0] line_cells;
		logic              frame_last;
	} in_word_t;

	typedef struct packed {
		logic [LINE_W-1:0] next_cells;
		logic              line_last;
	} out_word_t;

	// Bits one lane shows to its neighbors, already masked by the lane enable.
	typedef struct packed {
		logic up;
		logic mid;
		logic low;
	} lane_bits_t;

	// Line storage control shared by every cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// Queue push requests: word a goes in ahead of word b.
	typedef struct packed {
		logic a;
		logic b;
	} oq_push_t;

endpackage

### hw/rtl/life_rule_row_stencil_unit.sv
// Life rule row stencil unit: one generation of the B3/S23 automaton over a
// grid that arrives one line per word. Cells outside the grid are dead.
// The line channel (line_valid, line_stall, line_word) carries one grid line
// and its frame_last flag; a word is taken when line_valid is high and
// line_stall is low. The result channel (result_valid, result_stall,
// result_word) returns next-generation lines in grid order.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the line
// width; cfg_ready is always high and writes belong between frames.
// The first line of a frame gives no result unless it is also the last one,
// in which case it gives one word computed with dead lines above and below.
// Every later line gives the result for the line before it, and the last line
// gives a second word for itself. When the output queue is empty, an accepted
// line's first result word heads the queue in the cycle after it is taken.
// Throughput is one line per cycle while the four-entry output queue that
// follows the row of lane cells has room; it asserts line_stall while it holds
// three or more words. A stalled result word stays in place at the head of
// the queue. Reset empties the queue, clears the held lines, starts a new
// frame and sets the width to 64 cells.
module life_rule_row_stencil_unit #(
	parameter int LINE_BITS = lrs_pkg::LINE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        line_valid,
	output logic                        line_stall,
	input  lrs_pkg::in_word_t           line_word,
	output logic                        result_valid,
	input  logic                        result_stall,
	output lrs_pkg::out_word_t          result_word,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lrs_pkg::CPL_W-1:0]   cfg_data
);

	logic [lrs_pkg::CPL_W-1:0] cpl_q;
	logic [lrs_pkg::CPL_W-1:0] width_used;
	logic                      held_q;
	logic                      line_acc;
	logic                      queue_full;
	lrs_pkg::cell_ctl_t        ctl;
	lrs_pkg::oq_push_t         push;
	lrs_pkg::out_word_t        word_a;
	lrs_pkg::out_word_t        word_b;
	lrs_pkg::lane_bits_t       own [LINE_BITS];
	logic [LINE_BITS-1:0]      lane_en;
	logic [LINE_BITS-1:0]      res_a;
	logic [LINE_BITS-1:0]      res_b;

	// The configuration register is always ready to take a word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q <= lrs_pkg::CPL_RESET;
		end else if (cfg_valid) begin
			cpl_q <= cfg_data;
		end
	end

	// Widths above the number of lanes built count as all lanes.
	assign width_used = (cpl_q > lrs_pkg::CPL_W'(LINE_BITS)) ?
	                    lrs_pkg::CPL_W'(LINE_BITS) : cpl_q;

	assign line_stall = queue_full;
	assign line_acc   = line_valid & ~line_stall;

	// A last line ends the frame and clears the held lines; any other line
	// moves down into the middle slot.
	assign ctl.shift = line_acc & ~line_word.frame_last;
	assign ctl.clear = line_acc & line_word.frame_last;

	// held_q tells whether a middle line is waiting for its lower neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (line_acc) begin
			held_q <= ~line_word.frame_last;
		end
	end

	// One cell per lane. Each cell stores its lane's upper and middle bits and
	// trades masked bits with the cells on either side in every cycle.
	for (genvar i = 0; i < LINE_BITS; i++) begin : g_lane
		lrs_pkg::lane_bits_t nb_lo;
		lrs_pkg::lane_bits_t nb_hi;

		assign lane_en[i] = (lrs_pkg::CPL_W'(i) < width_used);

		if (i == 0) begin : g_lo_edge
			assign nb_lo = '0;
		end else begin : g_lo_link
			assign nb_lo = own[i-1];
		end

		if (i == LINE_BITS - 1) begin : g_hi_edge
			assign nb_hi = '0;
		end else begin : g_hi_link
			assign nb_hi = own[i+1];
		end

		lrs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.lane_en (lane_en[i]),
			.in_bit  (line_word.line_cells[i]),
			.nb_lo   (nb_lo),
			.nb_hi   (nb_hi),
			.own     (own[i]),
			.res_a   (res_a[i]),
			.res_b   (res_b[i])
		);
	end

	// The middle line's result goes out only when a middle line is held.
	// With no line held the stored lines are dead, so result b is then the
	// one-line grid case with dead lines above and below.
	assign push.a = line_acc & held_q;
	assign push.b = line_acc & line_word.frame_last;

	assign word_a.next_cells = lrs_pkg::LINE_W'(res_a);
	assign word_a.line_last  = 1'b0;
	assign word_b.next_cells = lrs_pkg::LINE_W'(res_b);
	assign word_b.line_last  = 1'b1;

	lrs_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.word_a     (word_a),
		.word_b     (word_b),
		.pop        (result_valid & ~result_stall),
		.head_valid (result_valid),
		.head_word  (result_word),
		.full       (queue_full)
	);

	// A last line always leaves at least its own word in the queue.
	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		line_acc && line_word.frame_last |=> result_valid)
		else $error("last line accepted but no result word queued");

	// The line channel is held off only by queued result words.
	a_stall_needs_words: assert property (@(posedge clk) disable iff (!arst_n)
		line_stall |-> result_valid)
		else $error("line channel stalled with an empty result queue");

	// After a first line of a frame, a line is held and nothing was queued.
	a_first_line_held: assert property (@(posedge clk) disable iff (!arst_n)
		line_acc && !held_q && !line_word.frame_last && !result_valid |=>
		held_q && !result_valid)
		else $error("first line of a frame produced a result word");

endmodule

### hw/rtl/lrs_cell.sv
module lrs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lrs_pkg::cell_ctl_t  ctl,
	input  logic                lane_en,
	input  logic                in_bit,
	input  lrs_pkg::lane_bits_t nb_lo,
	input  lrs_pkg::lane_bits_t nb_hi,
	output lrs_pkg::lane_bits_t own,
	output logic                res_a,
	output logic                res_b
);

	logic       upper_q;
	logic       middle_q;
	logic [3:0] n_a;
	logic [3:0] n_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctl.clear) begin
			upper_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctl.shift) begin
			upper_q  <= middle_q;
			middle_q <= in_bit;
		end
	end

	assign own.up  = upper_q & lane_en;
	assign own.mid = middle_q & lane_en;
	assign own.low = in_bit & lane_en;

	// Result a: the held middle line between the upper line and the new line.
	// Result b: the new line under the middle line with a dead line below.
	always_comb begin
		n_a = 4'(nb_lo.up) + 4'(own.up) + 4'(nb_hi.up)
		    + 4'(nb_lo.mid) + 4'(nb_hi.mid)
		    + 4'(nb_lo.low) + 4'(own.low) + 4'(nb_hi.low);
		n_b = 4'(nb_lo.mid) + 4'(own.mid) + 4'(nb_hi.mid)
		    + 4'(nb_lo.low) + 4'(nb_hi.low);
		res_a = lane_en & ((n_a == 4'd3) | (own.mid & (n_a == 4'd2)));
		res_b = lane_en & ((n_b == 4'd3) | (own.low & (n_b == 4'd2)));
	end

endmodule

### hw/rtl/lrs_out_queue.sv
module lrs_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  lrs_pkg::oq_push_t   push,
	input  lrs_pkg::out_word_t  word_a,
	input  lrs_pkg::out_word_t  word_b,
	input  logic                pop,
	output logic                head_valid,
	output lrs_pkg::out_word_t  head_word,
	output logic                full
);

	lrs_pkg::out_word_t                 mem_q [lrs_pkg::OQ_DEPTH];
	logic [lrs_pkg::OQ_IDX_W-1:0]       wr_q;
	logic [lrs_pkg::OQ_IDX_W-1:0]       rd_q;
	logic [lrs_pkg::OQ_CNT_W-1:0]       cnt_q;
	logic [lrs_pkg::OQ_CNT_W-1:0]       n_push;
	lrs_pkg::out_word_t                 first_word;

	assign n_push     = lrs_pkg::OQ_CNT_W'(push.a) + lrs_pkg::OQ_CNT_W'(push.b);
	assign first_word = push.a ? word_a : word_b;

	always_ff @(posedge clk) begin
		if (push.a | push.b) begin
			mem_q[wr_q] <= first_word;
		end
		if (push.a & push.b) begin
			mem_q[wr_q + lrs_pkg::OQ_IDX_W'(1)] <= word_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + lrs_pkg::OQ_IDX_W'(n_push);
			rd_q  <= rd_q + lrs_pkg::OQ_IDX_W'(pop);
			cnt_q <= cnt_q + n_push - lrs_pkg::OQ_CNT_W'(pop);
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head_word  = mem_q[rd_q];
	// Room for two words must be left before another line can be taken.
	assign full = (cnt_q > lrs_pkg::OQ_CNT_W'(lrs_pkg::OQ_DEPTH - 2));

endmodule

### dv/life_rule_row_stencil_unit_test.sv
module life_rule_row_stencil_unit_test;

	// The watchdog ends the run after this many cycles in which no word moves
	// on any channel. Receiver stalls are short random bursts, so a healthy run
	// never comes close.
	localparam int unsigned STALL_LIMIT = 5000;

	// Cycles to wait once the last expected word has arrived. The unit queues a
	// line's words in the cycle after it is taken. A line that starts a frame gives no
	// word, so it may still be settling when the queue runs dry.
	localparam int SETTLE_CYCLES = 4;

	localparam int IDLE_PERCENT = 32;
	localparam int RANDOM_LINES = 1150;

	logic clk;
	logic arst_n;
	logic line_valid;
	logic line_stall;
	lrs_pkg::in_word_t line_word;
	logic result_valid;
	logic result_stall;
	lrs_pkg::out_word_t result_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [lrs_pkg::CPL_W-1:0] cfg_data;

	// Shadow copy of the unit's line buffer and width register.
	logic [lrs_pkg::LINE_W-1:0] held_upper;
	logic [lrs_pkg::LINE_W-1:0] held_middle;
	int held_count;
	logic [lrs_pkg::CPL_W-1:0] line_width;

	// Next-generation words still owed by the unit, oldest first.
	lrs_pkg::out_word_t pending_lines[$];

	int mismatches;
	int lines_sent;
	int unsigned quiet_cycles;

	// While this is set, neither side inserts gaps or stalls.
	bit no_idle;

	life_rule_row_stencil_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_word(line_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word(result_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One generation of B3/S23 for the middle line. Cells at or above the
	// width in force are dead, both as neighbors and in the result. A width
	// above the line size counts as the full line.
	function automatic logic [lrs_pkg::LINE_W-1:0] life_generation(
		input logic [lrs_pkg::LINE_W-1:0] above,
		input logic [lrs_pkg::LINE_W-1:0] here,
		input logic [lrs_pkg::LINE_W-1:0] below,
		input logic [lrs_pkg::CPL_W-1:0] width
	);
		int lanes;
		int neighbors;
		logic [lrs_pkg::LINE_W-1:0] lane_mask;
		logic [lrs_pkg::LINE_W-1:0] born;
		lanes = (width > lrs_pkg::LINE_W) ? lrs_pkg::LINE_W : int'(width);
		lane_mask = (lanes >= lrs_pkg::LINE_W) ? '1 : ((64'd1 << lanes) - 64'd1);
		above = above & lane_mask;
		here = here & lane_mask;
		below = below & lane_mask;
		born = '0;
		for (int i = 0; i < lanes; i++) begin
			neighbors = 0;
			for (int j = i - 1; j <= i + 1; j++) begin
				if (j >= 0 && j < lrs_pkg::LINE_W) begin
					neighbors += above[j] + below[j];
					if (j != i)
						neighbors += here[j];
				end
			end
			if (neighbors == 3 || (here[i] && neighbors == 2))
				born[i] = 1'b1;
		end
		return born & lane_mask;
	endfunction

	function automatic lrs_pkg::out_word_t make_result(
		input logic [lrs_pkg::LINE_W-1:0] cells,
		input logic last
	);
		lrs_pkg::out_word_t w;
		w.next_cells = cells;
		w.line_last = last;
		return w;
	endfunction

	// Advance the shadow line buffer by one accepted line and queue the
	// words it releases.
	task automatic predict_line(input logic [lrs_pkg::LINE_W-1:0] cells, input logic last);
		if (held_count == 0) begin
			if (last) begin
				// A grid one line high: dead lines above and below.
				pending_lines.push_back(make_result(life_generation('0, cells, '0, line_width),
					1'b1));
			end else begin
				held_upper = '0;
				held_middle = cells;
				held_count = 1;
			end
		end else begin
			pending_lines.push_back(make_result(
				life_generation(held_upper, held_middle, cells, line_width), 1'b0));
			if (last) begin
				// The last line is finished against a dead line below and the
				// frame starts over.
				pending_lines.push_back(make_result(
					life_generation(held_middle, cells, '0, line_width), 1'b1));
				held_upper = '0;
				held_middle = '0;
				held_count = 0;
			end else begin
				held_upper = held_middle;
				held_middle = cells;
				held_count = 2;
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Offer one line word. Gaps are taken at falling edges before the word is
	// raised, and the word stays up until the rising edge that takes it. The
	// valid is left high so that back-to-back lines need no drop in between.
	task automatic send_line(input logic [lrs_pkg::LINE_W-1:0] cells, input logic last);
		lrs_pkg::in_word_t w;
		w.line_cells = cells;
		w.frame_last = last;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			line_valid <= 1'b0;
			line_word <= lrs_pkg::in_word_t'({$urandom, $urandom, 1'b0});
			@(negedge clk);
		end
		line_valid <= 1'b1;
		line_word <= w;
		do
			@(posedge clk);
		while (line_stall);
		predict_line(cells, last);
		lines_sent++;
	endtask

	// Let every owed word come out, then give the unit time to settle.
	task automatic wait_results_drained();
		@(negedge clk);
		line_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The width register is only written with the unit quiet.
	task automatic set_line_width(input logic [lrs_pkg::CPL_W-1:0] width);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data <= width;
		do
			@(posedge clk);
		while (!cfg_ready);
		line_width = width;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiving side stalls at random on every falling edge.
	always @(negedge clk) begin
		result_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Every word taken on the result channel is held against the oldest one
	// owed.
	always @(posedge clk) begin
		lrs_pkg::out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_lines.size() == 0) begin
				report_mismatch($sformatf("result word %h with no line pending", result_word));
			end else begin
				want = pending_lines.pop_front();
				if (result_word.next_cells !== want.next_cells)
					report_mismatch($sformatf("next_cells %h, expected %h",
						result_word.next_cells, want.next_cells));
				if (result_word.line_last !== want.line_last)
					report_mismatch($sformatf("line_last %b, expected %b",
						result_word.line_last, want.line_last));
			end
		end
	end

	// Watchdog: any handshake on any channel restarts the count.
	always @(posedge clk) begin
		if ((line_valid && !line_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("life_rule_row_stencil_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Frames one line high: the line sees dead lines on both sides. A full row
	// keeps its interior and loses both end cells; a checkerboard row dies out.
	task automatic test_single_line_frames();
		send_line('1, 1'b1);
		send_line('0, 1'b1);
		send_line(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_line(64'h5555_5555_5555_5555, 1'b1);
	endtask

	// Small known patterns: a blinker, blocks pressed against both edges to
	// show there is no wraparound, and a solid two-line frame.
	task automatic test_known_patterns();
		send_line('0, 1'b0);
		send_line(64'h0000_0000_0000_001C, 1'b0);
		send_line('0, 1'b1);
		send_line(64'hC000_0000_0000_0003, 1'b0);
		send_line(64'hC000_0000_0000_0003, 1'b1);
		send_line('1, 1'b0);
		send_line('1, 1'b1);
	endtask

	// Extremes of the width register: no cells at all, one cell, the full
	// register value and a value just over the line size, and a narrow grid.
	task automatic test_width_limits();
		set_line_width(7'd0);
		send_line('1, 1'b0);
		send_line('1, 1'b1);
		set_line_width(7'd1);
		send_line('1, 1'b0);
		send_line('1, 1'b0);
		send_line('1, 1'b1);
		set_line_width(7'd127);
		send_line('1, 1'b1);
		set_line_width(7'd65);
		send_line({$urandom, $urandom}, 1'b0);
		send_line({$urandom, $urandom}, 1'b1);
		set_line_width(7'd3);
		send_line(64'hFFFF_0000_0000_0007, 1'b1);
	endtask

	// Lines held across a width change keep all their bits; only the width in
	// force when a word is computed masks it.
	task automatic test_width_change_mid_frame();
		set_line_width(7'd64);
		send_line('1, 1'b0);
		set_line_width(7'd5);
		send_line('1, 1'b0);
		set_line_width(7'd64);
		send_line('1, 1'b1);
	endtask

	function automatic logic [lrs_pkg::CPL_W-1:0] pick_width();
		case ($urandom_range(9))
			0: return 7'd1;
			1: return 7'd2;
			2: return 7'd3;
			3: return 7'd63;
			4: return 7'd64;
			5: return 7'($urandom_range(65, 127));
			6: return ($urandom_range(9) == 0) ? 7'd0 : 7'd127;
			default: return 7'($urandom_range(4, 62));
		endcase
	endfunction

	// Whole frames of random height and content. Densities vary so that
	// births, survivals and deaths all get exercised; now and then a line is
	// the previous one with one cell flipped, which keeps shapes alive.
	task automatic test_random_frames();
		int height;
		logic [lrs_pkg::LINE_W-1:0] cells;
		cells = '0;
		while (lines_sent < RANDOM_LINES) begin
			if ($urandom_range(99) < 15)
				set_line_width(pick_width());
			height = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			for (int row = 0; row < height; row++) begin
				no_idle = (lines_sent >= 450 && lines_sent < 650);
				case ($urandom_range(3))
					0: cells = {$urandom, $urandom};
					1: cells = {$urandom, $urandom} & {$urandom, $urandom};
					2: cells = {$urandom, $urandom} | {$urandom, $urandom};
					default: cells = cells ^ (64'd1 << $urandom_range(63));
				endcase
				send_line(cells, row == height - 1);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		line_valid = 1'b0;
		line_word = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		held_upper = '0;
		held_middle = '0;
		held_count = 0;
		line_width = lrs_pkg::CPL_RESET;
		mismatches = 0;
		lines_sent = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_single_line_frames();
		test_known_patterns();
		test_width_limits();
		test_width_change_mid_frame();
		test_random_frames();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_lines.size() == 0) begin
			$display("life_rule_row_stencil_unit test passed");
		end else begin
			$display("life_rule_row_stencil_unit test failed");
		end
		$finish;
	end

endmodule
